@@ sv/usan_pkg.sv @@
// Shared types and constants of the UTF-8 text sanitizer.
`default_nettype none

package usan_pkg;

	// Byte codes used by the classifier
	localparam logic [7:0] SPACE     = 8'h20;
	localparam logic [7:0] TAB       = 8'h09;
	localparam logic [7:0] LF        = 8'h0A;
	localparam logic [7:0] CR        = 8'h0D;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_VAL  = 8'h80;
	localparam logic [7:0] LEAD2_MSK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL = 8'hC0;
	localparam logic [7:0] LEAD3_MSK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL = 8'hE0;
	localparam logic [7:0] LEAD4_MSK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL = 8'hF0;

	// Most bytes one input can produce
	localparam int unsigned MAX_OUT = 4;

	// All result bytes caused by one input byte
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;     // bytes[0] goes out first
		logic [1:0]              last_idx;  // index of the final byte
		logic                    text_end;  // input carried the text's last flag
	} pkt_t;

	// Front-to-queue write port
	typedef struct packed {
		logic valid;
		pkt_t pkt;
	} push_t;

endpackage

`default_nettype wire

@@ sv/utf8_text_sanitizer.sv @@
// Top level of the UTF-8 text sanitizer: front end, packet queue, back end.
//
// Channel | Dir | Payload                              | Handshake
// s_      | in  | tdata=text_byte, tlast=text_last     | s_tvalid/s_tready
// m_      | out | tdata=clean_byte, tuser=run_last,    | m_tvalid/m_tready
//         |     | tlast=text_end                       |
//
// An input byte is taken in every cycle while the packet queue has room.
// The back end sends one result byte per cycle while m_tready is high; each
// input yields zero to four result bytes, and the queue absorbs bursts.
// The result of an input is registered in the packet queue and then in the
// back end's current packet before it goes out.
// Reset clears the sequence state, queue pointers and back end valid flag.
// Output stalls back up into the queue only; input stalls only when it is full.
`default_nettype none

module utf8_text_sanitizer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] text_byte
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] clean_byte
	output logic [0:0] m_tuser,   // [0] run_last
	output logic       m_tlast
);

	usan_pkg::push_t push;
	usan_pkg::pkt_t  q_pkt;
	logic            q_full, q_not_empty, q_pop, accept, run_last;

	assign s_tready   = !q_full;
	assign accept     = s_tvalid && s_tready;
	assign m_tuser[0] = run_last;

	usan_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (s_tdata),
		.text_last (s_tlast),
		.push      (push)
	);

	usan_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_pkt    (q_pkt)
	);

	usan_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_pkt        (q_pkt),
		.q_pop        (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.out_run_last (run_last),
		.out_text_end (m_tlast)
	);

endmodule

`default_nettype wire

@@ sv/usan_front.sv @@
// Front end: accepts input bytes, tracks pending UTF-8 sequences, builds result packets.
`default_nettype none

module usan_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                accept,
	input  wire [7:0]          text_byte,
	input  wire                text_last,
	output usan_pkg::push_t    push
);

	logic [7:0] hb_q [3];
	logic [1:0] hc_q;
	logic [2:0] el_q;

	logic       has_held, is_cont, ext, complete, is_ctrl, fresh_lead;
	logic [2:0] lead_len;
	logic [2:0] n_out;
	logic [1:0] pre;
	logic [7:0] fresh_out;
	usan_pkg::pkt_t pkt;

	// Classify the byte
	always_comb begin
		is_cont  = (text_byte & usan_pkg::CONT_MASK) == usan_pkg::CONT_VAL;
		is_ctrl  = (text_byte < usan_pkg::SPACE) && (text_byte != usan_pkg::TAB) &&
		           (text_byte != usan_pkg::LF) && (text_byte != usan_pkg::CR);
		if ((text_byte & usan_pkg::LEAD2_MSK) == usan_pkg::LEAD2_VAL)
			lead_len = 3'd2;
		else if ((text_byte & usan_pkg::LEAD3_MSK) == usan_pkg::LEAD3_VAL)
			lead_len = 3'd3;
		else if ((text_byte & usan_pkg::LEAD4_MSK) == usan_pkg::LEAD4_VAL)
			lead_len = 3'd4;
		else
			lead_len = 3'd0;
		fresh_lead = lead_len != 3'd0;
		if (!text_byte[7])
			fresh_out = is_ctrl ? usan_pkg::SPACE : text_byte;
		else
			fresh_out = usan_pkg::SPACE;
		has_held = hc_q != 2'd0;
		ext      = has_held && is_cont;
		complete = ext && (({1'b0, hc_q} + 3'd1) >= el_q);
		pre      = (has_held && !is_cont) ? hc_q : 2'd0;
	end

	// Build the result packet
	always_comb begin
		pkt.text_end = text_last;
		if (complete) begin
			n_out = {1'b0, hc_q} + 3'd1;
			for (int i = 0; i < usan_pkg::MAX_OUT; i++) begin
				if (3'(i) < {1'b0, hc_q} && i < 3)
					pkt.bytes[i] = hb_q[i < 3 ? i : 0];
				else
					pkt.bytes[i] = text_byte;
			end
		end else if (ext) begin
			// sequence grows; a last flag turns everything held into spaces
			n_out = text_last ? ({1'b0, hc_q} + 3'd1) : 3'd0;
			for (int i = 0; i < usan_pkg::MAX_OUT; i++)
				pkt.bytes[i] = usan_pkg::SPACE;
		end else if (fresh_lead) begin
			n_out = {1'b0, pre} + {2'b00, text_last};
			for (int i = 0; i < usan_pkg::MAX_OUT; i++)
				pkt.bytes[i] = usan_pkg::SPACE;
		end else begin
			n_out = {1'b0, pre} + 3'd1;
			for (int i = 0; i < usan_pkg::MAX_OUT; i++)
				pkt.bytes[i] = (3'(i) < {1'b0, pre}) ? usan_pkg::SPACE : fresh_out;
		end
		pkt.last_idx = 2'(n_out - 3'd1);
		push.valid   = accept && (n_out != 3'd0);
		push.pkt     = pkt;
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= 2'd0;
			el_q <= 3'd0;
		end else if (accept) begin
			if (complete) begin
				hc_q <= 2'd0;
				el_q <= 3'd0;
			end else if (ext) begin
				hc_q <= text_last ? 2'd0 : hc_q + 2'd1;
				el_q <= text_last ? 3'd0 : el_q;
			end else if (fresh_lead) begin
				hc_q <= text_last ? 2'd0 : 2'd1;
				el_q <= text_last ? 3'd0 : lead_len;
			end else begin
				hc_q <= 2'd0;
				el_q <= 3'd0;
			end
		end
	end

	// Held bytes, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			if (ext && !complete) begin
				for (int i = 0; i < 3; i++)
					if (2'(i) == hc_q)
						hb_q[i] <= text_byte;
			end else if (!ext && fresh_lead) begin
				hb_q[0] <= text_byte;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/usan_queue.sv @@
// Packet queue between front and back end.
`default_nettype none

module usan_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire usan_pkg::push_t    push,
	output logic                    full,
	input  wire                     pop,
	output logic                    not_empty,
	output usan_pkg::pkt_t          rd_pkt
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	usan_pkg::pkt_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_pkt    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.pkt;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push.valid && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push.valid)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

@@ sv/usan_back.sv @@
// Back end: sends the bytes of each packet one beat at a time.
`default_nettype none

module usan_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     q_not_empty,
	input  wire usan_pkg::pkt_t     q_pkt,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [7:0]              out_byte,
	output logic                    out_run_last,
	output logic                    out_text_end
);

	usan_pkg::pkt_t cur_q;
	logic           cur_valid_q;
	logic [1:0]     idx_q;
	logic           fire, finishing;

	// Output beat and queue pop
	always_comb begin
		fire         = cur_valid_q && out_ready;
		finishing    = fire && (idx_q == cur_q.last_idx);
		q_pop        = q_not_empty && (!cur_valid_q || finishing);
		out_valid    = cur_valid_q;
		out_byte     = cur_q.bytes[idx_q];
		out_run_last = idx_q == cur_q.last_idx;
		out_text_end = out_run_last && cur_q.text_end;
	end

	// Current packet and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (q_pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (finishing) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Packet payload
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_pkt;
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> cur_valid_q && idx_q == 2'd0)
		else $error("packet load did not restart index");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= cur_q.last_idx)
		else $error("byte index past end of packet");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && !out_ready |=> cur_valid_q && $stable(idx_q))
		else $error("stalled packet moved");

endmodule

`default_nettype wire
